[hdl/tsi_pkg.sv]
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types and codes for the thermal safety interlock.
// ----------------------------------------------------------------------------
package tsi_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int HOLD_W     = 32;
  localparam int DROP_W     = 11;
  localparam int LIMIT_W    = 8;
  localparam int COUNT_W    = 8;
  // thresholds keep at least this many bits so their reset values fit
  localparam int THR_MIN_W  = 12;

  localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_MAX   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_MIN   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_CRIT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_MS    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_VERIFY_MS  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DROP       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_FAIL_LIMIT = 3'd6;

  // commands
  localparam logic [1:0] CMD_CHECK  = 2'd0;
  localparam logic [1:0] CMD_VERIFY = 2'd1;
  localparam logic [1:0] CMD_IO     = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  // safety state
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_WARN     = 2'd1;
  localparam logic [1:0] ST_SHUTDOWN = 2'd2;

  // shutdown causes
  localparam logic [2:0] SD_NONE    = 3'd0;
  localparam logic [2:0] SD_SENSOR  = 3'd1;
  localparam logic [2:0] SD_BOTH    = 3'd2;
  localparam logic [2:0] SD_OVER    = 3'd3;
  localparam logic [2:0] SD_LOW     = 3'd4;
  localparam logic [2:0] SD_IO      = 3'd5;

  // runaway causes
  localparam logic [2:0] RW_NONE    = 3'd0;
  localparam logic [2:0] RW_RELAY   = 3'd1;
  localparam logic [2:0] RW_RISING  = 3'd2;
  localparam logic [2:0] RW_NO_DROP = 3'd3;
  localparam logic [2:0] RW_IO      = 3'd4;

  // fan modes
  localparam logic [1:0] FAN_NORMAL = 2'd0;
  localparam logic [1:0] FAN_MAX    = 2'd1;
  localparam logic [1:0] FAN_FULL   = 2'd2;

  // latched flags and codes of the interlock
  typedef struct packed {
    logic       shutdown;
    logic       runaway;
    logic [1:0] state;
    logic       low_hold;
    logic [2:0] sd_code;
    logic [2:0] rw_code;
    logic [1:0] fan;
  } flags_t;

endpackage

[hdl/tsi_core.sv]
// ----------------------------------------------------------------------------
// tsi_core
// Next-state and result logic of the interlock for one word.
// ----------------------------------------------------------------------------
module tsi_core #(
  parameter int TIME_BITS = 32,
  parameter int TEMP_BITS = 12,
  parameter int TH_W      = 12
) (
  input  logic [1:0]                   cmd,
  input  logic signed [TEMP_BITS-1:0]  temp,
  input  logic                         sensor_ok,
  input  logic [tsi_pkg::COUNT_W-1:0]  fused_fail,
  input  logic [tsi_pkg::COUNT_W-1:0]  first_fail,
  input  logic [tsi_pkg::COUNT_W-1:0]  second_fail,
  input  logic [TIME_BITS-1:0]         now_ms,
  input  logic                         relays_ok,
  input  logic signed [TH_W-1:0]       temp_max,
  input  logic signed [TH_W-1:0]       temp_min,
  input  logic signed [TH_W-1:0]       temp_crit,
  input  logic [tsi_pkg::HOLD_W-1:0]   hold_ms,
  input  logic [tsi_pkg::HOLD_W-1:0]   verify_ms,
  input  logic [tsi_pkg::DROP_W-1:0]   verify_drop,
  input  logic [tsi_pkg::LIMIT_W-1:0]  fail_limit,
  input  tsi_pkg::flags_t              cur,
  input  logic [TIME_BITS-1:0]         cur_hold_start,
  input  logic [TIME_BITS-1:0]         cur_stamp,
  input  logic signed [TEMP_BITS-1:0]  cur_ref,
  output tsi_pkg::flags_t              nxt,
  output logic [TIME_BITS-1:0]         hold_start_nxt,
  output logic [TIME_BITS-1:0]         stamp_nxt,
  output logic signed [TEMP_BITS-1:0]  ref_nxt,
  output logic                         relay_req
);
  import tsi_pkg::*;

  localparam int EXT_W = TH_W + 2;
  localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

  logic signed [EXT_W-1:0] t_x, tmax_x, tmin_x, tcrit_x, ref_x, drop_x;
  logic signed [EXT_W-1:0] ref_plus, ref_minus;
  logic [TIME_BITS-1:0]    hold_el, verify_el;
  logic                    hold_done, in_window;
  logic                    t_pos, ref_unset;
  logic                    sensor_fail, both_fail, over_temp, low_band, warn_band;
  logic                    sd_fire, rw_fire;
  logic [2:0]              sd_cause, rw_cause;

  assign t_x       = EXT_W'(temp);
  assign tmax_x    = EXT_W'(temp_max);
  assign tmin_x    = EXT_W'(temp_min);
  assign tcrit_x   = EXT_W'(temp_crit);
  assign ref_x     = EXT_W'(cur_ref);
  assign drop_x    = EXT_W'($signed({1'b0, verify_drop}));
  assign ref_plus  = ref_x + drop_x;
  assign ref_minus = ref_x - t_x;

  // elapsed times wrap at the timestamp width
  assign hold_el   = now_ms - cur_hold_start;
  assign verify_el = now_ms - cur_stamp;
  assign hold_done = CMP_W'(hold_el) >= CMP_W'(hold_ms);
  assign in_window = CMP_W'(verify_el) < CMP_W'(verify_ms);

  assign t_pos     = !temp[TEMP_BITS-1] && (|temp);
  assign ref_unset = cur_ref[TEMP_BITS-1] || !(|cur_ref);

  assign sensor_fail = !sensor_ok && (fused_fail >= fail_limit);
  assign both_fail   = (first_fail >= fail_limit) && (second_fail >= fail_limit);
  assign over_temp   = sensor_ok && (t_x >= tmax_x);
  assign low_band    = sensor_ok && (t_x < tcrit_x) && t_pos;
  assign warn_band   = sensor_ok && (t_x < tmin_x) && (t_x >= tcrit_x);

  always_comb begin
    nxt            = cur;
    hold_start_nxt = cur_hold_start;
    stamp_nxt      = cur_stamp;
    ref_nxt        = cur_ref;
    relay_req      = 1'b0;
    sd_fire        = 1'b0;
    sd_cause       = SD_NONE;
    rw_fire        = 1'b0;
    rw_cause       = RW_NONE;

    unique case (cmd)
      CMD_CHECK: begin
        if (!cur.shutdown) begin
          priority if (sensor_fail) begin
            sd_fire  = 1'b1;
            sd_cause = SD_SENSOR;
          end else if (both_fail) begin
            sd_fire  = 1'b1;
            sd_cause = SD_BOTH;
          end else if (over_temp) begin
            sd_fire  = 1'b1;
            sd_cause = SD_OVER;
          end else if (low_band) begin
            if (!cur.low_hold) begin
              nxt.low_hold   = 1'b1;
              hold_start_nxt = now_ms;
              nxt.state      = ST_WARN;
            end else if (hold_done) begin
              sd_fire  = 1'b1;
              sd_cause = SD_LOW;
            end else begin
              nxt.state = ST_WARN;
            end
          end else begin
            nxt.low_hold = 1'b0;
            nxt.state    = warn_band ? ST_WARN : ST_OK;
          end
        end
      end
      CMD_VERIFY: begin
        if (cur.shutdown && !cur.runaway && sensor_ok) begin
          // first valid reading after shutdown only captures the reference
          if (ref_unset) begin
            ref_nxt = temp;
          end else if (in_window) begin
            if ((t_x >= tmax_x) && (t_x > ref_plus)) begin
              rw_fire  = 1'b1;
              rw_cause = RW_RISING;
            end
          end else if (ref_minus < drop_x) begin
            rw_fire  = 1'b1;
            rw_cause = RW_NO_DROP;
          end else begin
            ref_nxt   = temp;
            stamp_nxt = now_ms;
          end
        end
      end
      CMD_IO: begin
        if (!cur.shutdown) begin
          sd_fire  = 1'b1;
          sd_cause = SD_IO;
        end
        rw_fire  = 1'b1;
        rw_cause = RW_IO;
      end
      CMD_RESET: begin
        nxt            = '0;
        hold_start_nxt = '0;
        stamp_nxt      = '0;
        ref_nxt        = '0;
      end
      default: begin
      end
    endcase

    if (sd_fire) begin
      nxt.shutdown = 1'b1;
      nxt.state    = ST_SHUTDOWN;
      nxt.sd_code  = sd_cause;
      nxt.fan      = FAN_MAX;
      relay_req    = 1'b1;
      if (!cur.shutdown) begin
        stamp_nxt = now_ms;
        ref_nxt   = '0;
      end
      // failed relay turn-off takes precedence as the runaway cause
      if (!relays_ok) begin
        rw_fire  = 1'b1;
        rw_cause = RW_RELAY;
      end
    end

    if (rw_fire && !cur.runaway) begin
      nxt.runaway = 1'b1;
      nxt.rw_code = rw_cause;
      nxt.state   = ST_SHUTDOWN;
      nxt.fan     = FAN_FULL;
      relay_req   = 1'b1;
    end
  end

endmodule

[hdl/thermal_safety_interlock.sv]
// ----------------------------------------------------------------------------
// thermal_safety_interlock
// Shutdown and runaway interlock for a heated chamber.
// ----------------------------------------------------------------------------
// One word in, one result word out. An accepted word sits in the input register
// until the result register can advance; the interlock state and the result
// register then update together on the same edge. A new word can be taken every
// cycle; throughput is limited only by out_stall.
// Configuration writes are expected while no word is in flight.
module thermal_safety_interlock #(
  parameter int TIME_BITS = 32,
  parameter int TEMP_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_command,
  input  logic signed [TEMP_BITS-1:0]      in_temperature,
  input  logic                             in_sensor_ok,
  input  logic [tsi_pkg::COUNT_W-1:0]      in_fused_fail_count,
  input  logic [tsi_pkg::COUNT_W-1:0]      in_first_fail_count,
  input  logic [tsi_pkg::COUNT_W-1:0]      in_second_fail_count,
  input  logic [TIME_BITS-1:0]             in_now_ms,
  input  logic                             in_relays_off_ok,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_safety_state,
  output logic                             out_shutdown_flag,
  output logic                             out_runaway_flag,
  output logic [2:0]                       out_shutdown_cause,
  output logic [2:0]                       out_runaway_cause,
  output logic [1:0]                       out_fan_mode,
  output logic                             out_force_relays_off,
  input  logic                             cfg_we,
  input  logic [tsi_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tsi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tsi_pkg::*;

  localparam int TH_W = (TEMP_BITS > THR_MIN_W) ? TEMP_BITS : THR_MIN_W;

  // configuration registers
  logic signed [TH_W-1:0]  temp_max_r, temp_min_r, temp_crit_r;
  logic [HOLD_W-1:0]       hold_ms_r, verify_ms_r;
  logic [DROP_W-1:0]       drop_r;
  logic [LIMIT_W-1:0]      fail_limit_r;
  logic signed [TH_W-1:0]  cfg_temp;

  // input register
  logic                        s1_valid_r;
  logic [1:0]                  cmd_r;
  logic signed [TEMP_BITS-1:0] temp_r;
  logic                        ok_r;
  logic [COUNT_W-1:0]          fused_r, first_r, second_r;
  logic [TIME_BITS-1:0]        now_r;
  logic                        relays_ok_r;

  // interlock state
  flags_t                      flags_r, flags_nxt;
  logic [TIME_BITS-1:0]        hold_start_r, hold_start_nxt;
  logic [TIME_BITS-1:0]        stamp_r, stamp_nxt;
  logic signed [TEMP_BITS-1:0] ref_r, ref_nxt;
  logic                        relay_req;

  // result register
  logic                        out_valid_r;
  flags_t                      res_r;
  logic                        res_relay_r;

  logic advance, fire, in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_temp = TH_W'($signed(cfg_wdata[TEMP_BITS-1:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_max_r   <= TH_W'(640);
      temp_min_r   <= TH_W'(480);
      temp_crit_r  <= TH_W'(320);
      hold_ms_r    <= 32'd120000;
      verify_ms_r  <= 32'd300000;
      drop_r       <= 11'd16;
      fail_limit_r <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TEMP_MAX:   temp_max_r   <= cfg_temp;
        CFG_TEMP_MIN:   temp_min_r   <= cfg_temp;
        CFG_TEMP_CRIT:  temp_crit_r  <= cfg_temp;
        CFG_HOLD_MS:    hold_ms_r    <= cfg_wdata[HOLD_W-1:0];
        CFG_VERIFY_MS:  verify_ms_r  <= cfg_wdata[HOLD_W-1:0];
        CFG_DROP:       drop_r       <= cfg_wdata[DROP_W-1:0];
        CFG_FAIL_LIMIT: fail_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r       <= in_command;
      temp_r      <= in_temperature;
      ok_r        <= in_sensor_ok;
      fused_r     <= in_fused_fail_count;
      first_r     <= in_first_fail_count;
      second_r    <= in_second_fail_count;
      now_r       <= in_now_ms;
      relays_ok_r <= in_relays_off_ok;
    end
  end

  tsi_core #(
    .TIME_BITS (TIME_BITS),
    .TEMP_BITS (TEMP_BITS),
    .TH_W      (TH_W)
  ) u_core (
    .cmd            (cmd_r),
    .temp           (temp_r),
    .sensor_ok      (ok_r),
    .fused_fail     (fused_r),
    .first_fail     (first_r),
    .second_fail    (second_r),
    .now_ms         (now_r),
    .relays_ok      (relays_ok_r),
    .temp_max       (temp_max_r),
    .temp_min       (temp_min_r),
    .temp_crit      (temp_crit_r),
    .hold_ms        (hold_ms_r),
    .verify_ms      (verify_ms_r),
    .verify_drop    (drop_r),
    .fail_limit     (fail_limit_r),
    .cur            (flags_r),
    .cur_hold_start (hold_start_r),
    .cur_stamp      (stamp_r),
    .cur_ref        (ref_r),
    .nxt            (flags_nxt),
    .hold_start_nxt (hold_start_nxt),
    .stamp_nxt      (stamp_nxt),
    .ref_nxt        (ref_nxt),
    .relay_req      (relay_req)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r      <= '0;
      hold_start_r <= '0;
      stamp_r      <= '0;
      ref_r        <= '0;
    end else if (fire) begin
      flags_r      <= flags_nxt;
      hold_start_r <= hold_start_nxt;
      stamp_r      <= stamp_nxt;
      ref_r        <= ref_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r       <= flags_nxt;
      res_relay_r <= relay_req;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_safety_state     = res_r.state;
  assign out_shutdown_flag    = res_r.shutdown;
  assign out_runaway_flag     = res_r.runaway;
  assign out_shutdown_cause   = res_r.sd_code;
  assign out_runaway_cause    = res_r.rw_code;
  assign out_fan_mode         = res_r.fan;
  assign out_force_relays_off = res_relay_r;

  // runaway is only ever latched on top of a shutdown
  a_runaway_needs_shutdown: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.runaway |-> flags_r.shutdown)
    else $error("runaway latched without shutdown");

  a_shutdown_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_shutdown_flag |-> out_safety_state == ST_SHUTDOWN)
    else $error("shutdown flag with non-shutdown state");

  a_word_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word did not reach the result register");

endmodule
